// ===== hdl/cau_pkg.sv =====
// shared types and constants of the complex arithmetic unit
// no dependencies; used by every other file of the block except cau_sqrt
package cau_pkg;

	localparam logic [2:0] CMD_MUL   = 3'd0;
	localparam logic [2:0] CMD_DIV   = 3'd1;
	localparam logic [2:0] CMD_CONJ  = 3'd2;
	localparam logic [2:0] CMD_MAG   = 3'd3;
	localparam logic [2:0] CMD_SCALE = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_MAX = 32'h8000_0000;

	// quotient bits 32..0; anything larger is caught before the first step
	localparam int QUO_BITS  = 33;
	localparam int DIV_LAT   = QUO_BITS + 1;
	localparam int SQRT_LAT  = 32;
	localparam int SQRT_PAD  = DIV_LAT - SQRT_LAT;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] re;
		logic [31:0] im;
		logic [1:0]  st;
		logic        den_zero;
	} side_t;

	typedef struct packed {
		logic                neg;
		logic                ovf;
		logic [QUO_BITS-1:0] quo;
	} div_res_t;

endpackage

// ===== hdl/cau_div.sv =====
// pipelined restoring divider: |num| * 2^FRAC_BITS / den, one quotient bit per stage
// depends on cau_pkg
module cau_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [65:0]    num,
	input  logic [63:0]           den,
	output cau_pkg::div_res_t     res
);

	localparam int QB = cau_pkg::QUO_BITS;
	localparam int NW = 64 + FRAC_BITS;
	localparam int CW = 64 + QB;

	logic [63:0]    mag;
	logic [NW-1:0]  nfull;
	logic           ovf;

	logic [63:0]    rem_s [0:QB];
	logic [63:0]    den_s [0:QB];
	logic [QB-1:0]  low_s [0:QB];
	logic [QB-1:0]  quo_s [0:QB];
	logic           neg_s [0:QB];
	logic           ovf_s [0:QB];

	always_comb begin
		mag   = num[65] ? 64'(-num) : num[63:0];
		nfull = {mag, {FRAC_BITS{1'b0}}};
		// quotient would need more than QB bits
		ovf   = ({{(CW-NW){1'b0}}, nfull} >= {den, {QB{1'b0}}});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= 64'(nfull[NW-1:QB]);
			den_s[0] <= den;
			low_s[0] <= nfull[QB-1:0];
			quo_s[0] <= '0;
			neg_s[0] <= num[65];
			ovf_s[0] <= ovf;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_step
		logic [64:0] r_in;
		logic [65:0] diff;
		logic        take;

		always_comb begin
			r_in = {rem_s[j], low_s[j][QB-1-j]};
			diff = {1'b0, r_in} - {2'b00, den_s[j]};
			take = !diff[65];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= take ? diff[63:0] : r_in[63:0];
				den_s[j+1] <= den_s[j];
				low_s[j+1] <= low_s[j];
				quo_s[j+1] <= {quo_s[j][QB-2:0], take};
				neg_s[j+1] <= neg_s[j];
				ovf_s[j+1] <= ovf_s[j];
			end
		end
	end

	assign res = '{neg: neg_s[QB], ovf: ovf_s[QB], quo: quo_s[QB]};

endmodule

// ===== hdl/cau_sqrt.sv =====
// pipelined integer square root, one root bit per stage
// depends on nothing outside this file
module cau_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	logic [33:0] rem_s  [1:32];
	logic [31:0] root_s [1:32];
	logic [63:0] rad_s  [1:32];

	for (genvar k = 0; k < 32; k++) begin : g_step
		logic [33:0] p_rem;
		logic [31:0] p_root;
		logic [63:0] p_rad;
		logic [35:0] rem_in;
		logic [35:0] trial;
		logic        take;

		if (k == 0) begin : g_first
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_rad  = rad;
		end else begin : g_next
			assign p_rem  = rem_s[k];
			assign p_root = root_s[k];
			assign p_rad  = rad_s[k];
		end

		always_comb begin
			rem_in = {p_rem, p_rad[2*(31-k)+1 -: 2]};
			trial  = {2'b00, p_root, 2'b01};
			take   = (rem_in >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? 34'(rem_in - trial) : rem_in[33:0];
				root_s[k+1] <= {p_root[30:0], take};
				rad_s[k+1]  <= p_rad;
			end
		end
	end

	assign root = root_s[32];

endmodule

// ===== hdl/complex_arithmetic_unit_core.sv =====
// items pass in order through stage 1, stage 2, the divider or side line, and the output register
// throughput: one item per cycle unless the output stalls; the pipeline length is set by the 34-stage divider
// a stalled output holds every stage, nothing is dropped or repeated
// reset (arst_n low, asynchronous) clears all valid bits and sets scale_factor to 1.0
// depends on cau_pkg, cau_div, cau_sqrt
module complex_arithmetic_unit_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // a_real, a_imag, b_real, b_imag
	input  logic [2:0]   s_tuser,   // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // out_real, out_imag
	output logic [1:0]   m_tuser,   // status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data   // scale_factor
);

	localparam int DL = cau_pkg::DIV_LAT;
	localparam int SP = cau_pkg::SQRT_PAD;

	logic               en;
	logic signed [31:0] scale_q;

	logic signed [31:0] a_re, a_im, b_re, b_im, op0, op1;

	logic               vld_s1, vld_s2;
	logic [2:0]         cmd_s1, cmd_s2;
	logic signed [31:0] a_s1, b_s1, a_s2, b_s2;
	logic signed [63:0] m0_s1, m1_s1, m2_s1, m3_s1, m4_s1, m5_s1;
	logic signed [65:0] sr_s2, si_s2;
	logic [63:0]        den_s2;

	logic               vld_line [0:DL-1];
	cau_pkg::side_t     side_s   [0:DL-1];
	cau_pkg::side_t     side_in, side_out;

	cau_pkg::div_res_t  div_re, div_im;
	logic [31:0]        sqrt_root;
	logic [31:0]        root_pad [0:SP-1];

	logic [31:0]        fin_re, fin_im;
	logic [1:0]         fin_st;

	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 32'sd65536;
		end else if (cfg_valid) begin
			scale_q <= cfg_data;
		end
	end

	// stage 1: operand select and the six products
	always_comb begin
		a_re = s_tdata[31:0];
		a_im = s_tdata[63:32];
		b_re = s_tdata[95:64];
		b_im = s_tdata[127:96];
		unique case (s_tuser)
			cau_pkg::CMD_SCALE: begin
				op0 = scale_q;
				op1 = scale_q;
			end
			cau_pkg::CMD_MAG: begin
				op0 = a_re;
				op1 = a_im;
			end
			default: begin
				op0 = b_re;
				op1 = b_im;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= s_tuser;
			a_s1   <= a_re;
			b_s1   <= a_im;
			m0_s1  <= a_re * op0;
			m1_s1  <= a_im * op1;
			m2_s1  <= a_re * b_im;
			m3_s1  <= a_im * b_re;
			m4_s1  <= b_re * b_re;
			m5_s1  <= b_im * b_im;
		end
	end

	// stage 2: sums of products and the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			den_s2 <= $unsigned(m4_s1) + $unsigned(m5_s1);
			priority if (cmd_s1 == cau_pkg::CMD_MUL) begin
				sr_s2 <= 66'(m0_s1) - 66'(m1_s1);
			end else if (cmd_s1 == cau_pkg::CMD_SCALE) begin
				sr_s2 <= 66'(m0_s1);
			end else begin
				sr_s2 <= 66'(m0_s1) + 66'(m1_s1);
			end
			priority if (cmd_s1 == cau_pkg::CMD_SCALE) begin
				si_s2 <= 66'(m1_s1);
			end else if (cmd_s1 == cau_pkg::CMD_DIV) begin
				si_s2 <= 66'(m3_s1) - 66'(m2_s1);
			end else begin
				si_s2 <= 66'(m3_s1) + 66'(m2_s1);
			end
		end
	end

	// stage 3 side path: multiply, scale and conjugate finish here
	function automatic logic [32:0] sat_shift(input logic signed [65:0] x);
		logic signed [65:0] sh;
		sh = x >>> FRAC_BITS;
		if (sh > 66'sd2147483647) begin
			return {1'b1, cau_pkg::POS_MAX};
		end else if (sh < -66'sd2147483648) begin
			return {1'b1, cau_pkg::NEG_MAX};
		end
		return {1'b0, sh[31:0]};
	endfunction

	always_comb begin
		logic [32:0] r, i;
		r = sat_shift(sr_s2);
		i = sat_shift(si_s2);
		side_in          = '0;
		side_in.cmd      = cmd_s2;
		side_in.den_zero = (den_s2 == 64'd0);
		unique case (cmd_s2)
			cau_pkg::CMD_MUL, cau_pkg::CMD_SCALE: begin
				side_in.re = r[31:0];
				side_in.im = i[31:0];
				side_in.st = (r[32] || i[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			end
			cau_pkg::CMD_CONJ: begin
				side_in.re = a_s2;
				// negating the most negative value saturates
				if (b_s2 == cau_pkg::NEG_MAX) begin
					side_in.im = cau_pkg::POS_MAX;
					side_in.st = cau_pkg::ST_SAT;
				end else begin
					side_in.im = 32'(-b_s2);
					side_in.st = cau_pkg::ST_OK;
				end
			end
			default: begin
				side_in.st = cau_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < DL; n++) begin
				vld_line[n] <= 1'b0;
			end
		end else if (en) begin
			vld_line[0] <= vld_s2;
			for (int n = 1; n < DL; n++) begin
				vld_line[n] <= vld_line[n-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int n = 1; n < DL; n++) begin
				side_s[n] <= side_s[n-1];
			end
		end
	end

	cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
		.clk (clk),
		.en  (en),
		.num (sr_s2),
		.den (den_s2),
		.res (div_re)
	);

	cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
		.clk (clk),
		.en  (en),
		.num (si_s2),
		.den (den_s2),
		.res (div_im)
	);

	cau_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sr_s2[63:0]),
		.root (sqrt_root)
	);

	// align the root with the divider output
	always_ff @(posedge clk) begin
		if (en) begin
			root_pad[0] <= sqrt_root;
			for (int n = 1; n < SP; n++) begin
				root_pad[n] <= root_pad[n-1];
			end
		end
	end

	function automatic logic [32:0] sat_div(input cau_pkg::div_res_t d);
		if (d.ovf) begin
			return {1'b1, d.neg ? cau_pkg::NEG_MAX : cau_pkg::POS_MAX};
		end else if (!d.neg) begin
			if (d.quo > 33'(cau_pkg::POS_MAX)) begin
				return {1'b1, cau_pkg::POS_MAX};
			end
			return {1'b0, d.quo[31:0]};
		end else if (d.quo > 33'(cau_pkg::NEG_MAX)) begin
			return {1'b1, cau_pkg::NEG_MAX};
		end
		return {1'b0, 32'(-d.quo)};
	endfunction

	assign side_out = side_s[DL-1];

	always_comb begin
		logic [32:0] qr, qi;
		qr     = sat_div(div_re);
		qi     = sat_div(div_im);
		fin_re = side_out.re;
		fin_im = side_out.im;
		fin_st = side_out.st;
		unique case (side_out.cmd)
			cau_pkg::CMD_DIV: begin
				if (side_out.den_zero) begin
					fin_re = '0;
					fin_im = '0;
					fin_st = cau_pkg::ST_DIV0;
				end else begin
					fin_re = qr[31:0];
					fin_im = qi[31:0];
					fin_st = (qr[32] || qi[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
				end
			end
			cau_pkg::CMD_MAG: begin
				fin_im = '0;
				if (root_pad[SP-1] > cau_pkg::POS_MAX) begin
					fin_re = cau_pkg::POS_MAX;
					fin_st = cau_pkg::ST_SAT;
				end else begin
					fin_re = root_pad[SP-1];
					fin_st = cau_pkg::ST_OK;
				end
			end
			default: begin
				fin_re = side_out.re;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_line[DL-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {fin_im, fin_re};
			m_tuser <= fin_st;
		end
	end

endmodule

// ===== hdl/cau_chk.sv =====
// port-level checks of the complex arithmetic unit, bound to the top level
// depends on cau_pkg and complex_arithmetic_unit_core
module cau_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata,
	input logic [1:0]   m_tuser
);

	// a result that is not taken stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a waiting result stalls the input side
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 2'd3)
		else $error("undefined status code");

	// divide by zero always returns zero
	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == cau_pkg::ST_DIV0 |-> m_tdata == 64'd0)
		else $error("divide by zero with nonzero data");

endmodule

bind complex_arithmetic_unit_core cau_chk u_cau_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for complex_arithmetic_unit_core: random and directed complex items
// depends on cau_pkg and the core; predicts each result and compares it in order
`timescale 1ns / 100ps

module testbench;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic [1:0]  st;
	} cplx_res_t;

	// exact complex arithmetic on the Q16.16 operands
	function automatic cplx_res_t cau_predict(logic [2:0] cmd, logic signed [31:0] ar,
			logic signed [31:0] ai, logic signed [31:0] br, logic signed [31:0] bi,
			logic signed [31:0] k);
		cplx_res_t r;
		logic signed [127:0] x, y, den, q;
		logic [127:0] s, rt, bt;
		bit sat;
		sat = 0;
		r = '0;
		x = 0;
		y = 0;
		case (cmd)
			cau_pkg::CMD_MUL: begin
				x = (128'(ar) * 128'(br) - 128'(ai) * 128'(bi)) >>> 16;
				y = (128'(ar) * 128'(bi) + 128'(ai) * 128'(br)) >>> 16;
			end
			cau_pkg::CMD_DIV: begin
				den = 128'(br) * 128'(br) + 128'(bi) * 128'(bi);
				if (den == 0) begin
					r.st = cau_pkg::ST_DIV0;
				end else begin
					q = ((128'(ar) * 128'(br) + 128'(ai) * 128'(bi)) <<< 16);
					x = q / den;
					q = ((128'(ai) * 128'(br) - 128'(ar) * 128'(bi)) <<< 16);
					y = q / den;
				end
			end
			cau_pkg::CMD_CONJ: begin
				x = 128'(ar);
				y = -128'(ai);
			end
			cau_pkg::CMD_MAG: begin
				s = 128'(ar) * 128'(ar) + 128'(ai) * 128'(ai);
				rt = 0;
				for (int i = 31; i >= 0; i--) begin
					bt = rt | (128'd1 << i);
					if (bt * bt <= s)
						rt = bt;
				end
				x = rt;
			end
			cau_pkg::CMD_SCALE: begin
				x = (128'(ar) * 128'(k)) >>> 16;
				y = (128'(ai) * 128'(k)) >>> 16;
			end
			default: ;
		endcase
		if (x > 128'sh7FFF_FFFF) begin
			r.re = cau_pkg::POS_MAX;
			sat = 1;
		end else if (x < -128'sh8000_0000) begin
			r.re = cau_pkg::NEG_MAX;
			sat = 1;
		end else begin
			r.re = x[31:0];
		end
		if (y > 128'sh7FFF_FFFF) begin
			r.im = cau_pkg::POS_MAX;
			sat = 1;
		end else if (y < -128'sh8000_0000) begin
			r.im = cau_pkg::NEG_MAX;
			sat = 1;
		end else begin
			r.im = y[31:0];
		end
		if (r.st == cau_pkg::ST_OK && sat)
			r.st = cau_pkg::ST_SAT;
		return r;
	endfunction

	class cau_scoreboard;
		cplx_res_t pending[$];
		int errors;
		logic [31:0] scale;

		function void note_item(logic [2:0] cmd, logic [127:0] d);
			pending.push_back(cau_predict(cmd, d[31:0], d[63:32], d[95:64], d[127:96], scale));
		endfunction

		function void check_result(logic [63:0] d, logic [1:0] st);
			cplx_res_t e;
			if (pending.size() == 0) begin
				$error("result with nothing pending: %h %0d", d, st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[31:0] !== e.re) begin
				$error("out_real expected %h actual %h", e.re, d[31:0]);
				errors++;
			end
			if (d[63:32] !== e.im) begin
				$error("out_imag expected %h actual %h", e.im, d[63:32]);
				errors++;
			end
			if (st !== e.st) begin
				$error("status expected %0d actual %0d", e.st, st);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [63:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;

	cau_scoreboard sb = new();
	int idle_pct = 34;
	bit hold_off = 0;

	always #2 clk = ~clk;

	complex_arithmetic_unit_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// receiver: random stall, long hold-off when asked
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		m_tready <= !hold_off && ($urandom_range(99) >= idle_pct);
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
			4: return 32'($signed($urandom_range(512)) - 256);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(logic [2:0] cmd, logic [127:0] d);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_item(cmd, d);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_scale(logic [31:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		sb.scale = v;
		@(posedge clk);
	endtask

	task automatic send_random(int n);
		logic [2:0] cmd;
		for (int i = 0; i < n; i++) begin
			cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
			send_item(cmd, {pick_word(), pick_word(), pick_word(), pick_word()});
		end
	endtask

	initial begin
		logic [31:0] scales[5];
		sb.scale = 32'h0001_0000;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: each command, extremes, divide by zero, conjugate of the most negative, two undefined codes
		send_item(cau_pkg::CMD_MUL, {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		send_item(cau_pkg::CMD_MUL, {32'h0, 32'h0002_0000, 32'h0, 32'h0001_8000});
		send_item(cau_pkg::CMD_DIV, {32'h0, 32'h0, 32'h0003_0000, 32'h0001_0000});
		send_item(cau_pkg::CMD_DIV, {32'h0, 32'h0001, 32'h0, 32'h7FFF_FFFF});
		send_item(cau_pkg::CMD_DIV, {32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000});
		send_item(cau_pkg::CMD_DIV, {32'h0001, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF});
		send_item(cau_pkg::CMD_CONJ, {64'h0, 32'h8000_0000, 32'h0001_0000});
		send_item(cau_pkg::CMD_CONJ, {64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
		send_item(cau_pkg::CMD_MAG, {64'h0, 32'h8000_0000, 32'h8000_0000});
		send_item(cau_pkg::CMD_MAG, {64'h0, 32'h0004_0000, 32'h0003_0000});
		send_item(cau_pkg::CMD_SCALE, {64'h0, 32'h8000_0000, 32'h7FFF_FFFF});
		send_item(3'd5, {4{32'h1234_5678}});
		send_item(3'd7, {4{32'hFFFF_FFFF}});
		drain();
		scales = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_0000, $urandom};
		foreach (scales[j]) begin
			write_scale(scales[j]);
			send_item(cau_pkg::CMD_SCALE, {64'h0, 32'h8000_0000, 32'h7FFF_FFFF});
			send_random(j == 0 ? 150 : 300);
			drain();
		end
		// with no idling, fill the pipeline against a stalled receiver, then release the receiver
		write_scale(32'h0002_8000);
		idle_pct = 0;
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			send_random(200);
		join
		idle_pct = 34;
		send_random(300);
		drain();
		if (sb.errors == 0)
			$display("complex_arithmetic_unit_core regression: pass");
		else
			$display("complex_arithmetic_unit_core regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("complex_arithmetic_unit_core regression: fail");
		$finish;
	end

endmodule
